// ===== hw/rtl/ssph_pkg.sv =====
package ssph_pkg;

    localparam int RSSI_W     = 8;
    localparam int BIN_W      = 7;
    localparam int FREQ_W     = 27;
    localparam int STEP_W     = 14;
    localparam int LOG_W      = 2;
    localparam int HOLD_W     = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 27;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_REMEASURE = 2'd1,
        REQ_BLACKLIST = 2'd2,
        REQ_RESTART   = 2'd3
    } req_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_FREQ    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BINS_LOG      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_LEVEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_SWEEPS   = 3'd4;

    localparam logic [FREQ_W-1:0] START_FREQ_RST    = 27'd43840000;
    localparam logic [STEP_W-1:0] STEP_SIZE_RST     = 14'd2500;
    localparam logic [LOG_W-1:0]  BINS_LOG_RST      = 2'd1;
    localparam logic [RSSI_W-1:0] TRIGGER_LEVEL_RST = 8'd50;
    localparam logic [HOLD_W-1:0] HOLD_SWEEPS_RST   = 8'd16;

    // 255 in the history marks a blacklisted bin; as a floor it means none yet
    localparam logic [RSSI_W-1:0] LEVEL_BLACKLIST = 8'd255;
    localparam logic [RSSI_W-1:0] LEVEL_NONE      = 8'd255;
    localparam logic [HOLD_W-1:0] AGE_MAX         = 8'd255;

    // item leaving the front stage
    typedef struct packed {
        logic              valid;
        req_t              req;
        logic [RSSI_W-1:0] rssi;
        logic              sweep_end;
    } item_t;

    // result leaving the tracking stage
    typedef struct packed {
        logic              valid;
        logic [BIN_W-1:0]  bin_index;
        logic              skipped;
        logic              sweep_end;
        logic [RSSI_W-1:0] peak_level;
        logic [RSSI_W-1:0] floor_level;
        logic              over_level;
    } res_t;

    typedef struct packed {
        logic [M_TDATA_W-1:0] tdata;
        logic                 tlast;
        logic [M_TUSER_W-1:0] tuser;
    } m_beat_t;

endpackage

// ===== hw/rtl/ssph_ram.sv =====
module ssph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ssph_track.sv =====
module ssph_track #(
    parameter int AW = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssph_pkg::item_t             item,
    input  logic [AW-1:0]               item_pos,
    input  logic [ssph_pkg::RSSI_W-1:0] hist_rdata,
    input  logic [ssph_pkg::RSSI_W-1:0] trigger_level,
    input  logic [ssph_pkg::HOLD_W-1:0] hold_sweeps,
    input  logic                        trig_wr,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [ssph_pkg::RSSI_W-1:0] mem_wdata,
    output ssph_pkg::res_t              res,
    output logic [AW-1:0]               held_bin
);
    import ssph_pkg::*;

    logic              clearing_reg, clearing_next;
    logic [RSSI_W-1:0] sweep_max_reg, sweep_max_next;
    logic [AW-1:0]     sweep_max_bin_reg, sweep_max_bin_next;
    logic [RSSI_W-1:0] running_min_reg, running_min_next;
    logic [RSSI_W-1:0] held_level_reg, held_level_next;
    logic [AW-1:0]     held_bin_reg, held_bin_next;
    logic              held_valid_reg, held_valid_next;
    logic [HOLD_W-1:0] hold_age_reg, hold_age_next;
    logic [RSSI_W-1:0] auto_trigger_reg, auto_trigger_next;
    res_t              res_reg, res_next;

    // last cycle's write, for a read issued in that same cycle
    logic              fwd_we_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [RSSI_W-1:0] fwd_data_reg;

    logic [RSSI_W-1:0] hist;
    logic [HOLD_W-1:0] age_inc;
    logic [RSSI_W-1:0] eff_trigger;
    logic [AW-1:0]     idx;
    logic              skip;

    assign hist = (fwd_we_reg && fwd_addr_reg == item_pos) ? fwd_data_reg : hist_rdata;
    assign age_inc = (hold_age_reg != AGE_MAX) ? hold_age_reg + 1'b1 : hold_age_reg;

    always_comb begin
        clearing_next      = clearing_reg;
        sweep_max_next     = sweep_max_reg;
        sweep_max_bin_next = sweep_max_bin_reg;
        running_min_next   = running_min_reg;
        held_level_next    = held_level_reg;
        held_bin_next      = held_bin_reg;
        held_valid_next    = held_valid_reg;
        hold_age_next      = hold_age_reg;
        auto_trigger_next  = auto_trigger_reg;
        mem_we             = 1'b0;
        mem_waddr          = item_pos;
        mem_wdata          = item.rssi;
        idx                = '0;
        skip               = 1'b0;
        if (item.valid) begin
            case (item.req)
                REQ_SAMPLE: begin
                    idx = item_pos;
                    if (!clearing_reg && hist == LEVEL_BLACKLIST) begin
                        skip = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        if (item.rssi > sweep_max_reg) begin
                            sweep_max_next     = item.rssi;
                            sweep_max_bin_next = item_pos;
                        end
                        if (item.rssi < running_min_reg) begin
                            running_min_next = item.rssi;
                        end
                    end
                    if (item.sweep_end) begin
                        clearing_next = 1'b0;
                        hold_age_next = age_inc;
                        if (trigger_level == '0 && auto_trigger_reg == '0) begin
                            auto_trigger_next = sweep_max_next;
                        end
                        if (!held_valid_reg || sweep_max_next > held_level_reg
                                || age_inc >= hold_sweeps) begin
                            hold_age_next   = '0;
                            held_level_next = sweep_max_next;
                            held_bin_next   = sweep_max_bin_next;
                            held_valid_next = 1'b1;
                        end
                        sweep_max_next     = '0;
                        sweep_max_bin_next = '0;
                    end
                end
                REQ_REMEASURE: begin
                    idx             = held_bin_reg;
                    mem_we          = 1'b1;
                    mem_waddr       = held_bin_reg;
                    held_level_next = item.rssi;
                end
                REQ_BLACKLIST: begin
                    idx             = held_bin_reg;
                    mem_we          = 1'b1;
                    mem_waddr       = held_bin_reg;
                    mem_wdata       = LEVEL_BLACKLIST;
                    held_level_next = '0;
                    held_valid_next = 1'b0;
                end
                REQ_RESTART: begin
                    clearing_next      = 1'b1;
                    sweep_max_next     = '0;
                    sweep_max_bin_next = '0;
                    held_level_next    = '0;
                    held_valid_next    = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (trig_wr) begin
            auto_trigger_next = '0;
        end
    end

    assign eff_trigger = (trigger_level != '0) ? trigger_level : auto_trigger_next;

    always_comb begin
        res_next.valid       = item.valid;
        res_next.bin_index   = BIN_W'(idx);
        res_next.skipped     = skip;
        res_next.sweep_end   = item.sweep_end;
        res_next.peak_level  = held_level_next;
        res_next.floor_level = running_min_next;
        res_next.over_level  = held_level_next >= eff_trigger;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg      <= 1'b1;
            sweep_max_reg     <= '0;
            sweep_max_bin_reg <= '0;
            running_min_reg   <= LEVEL_NONE;
            held_level_reg    <= '0;
            held_bin_reg      <= '0;
            held_valid_reg    <= 1'b0;
            hold_age_reg      <= '0;
            auto_trigger_reg  <= '0;
            res_reg.valid     <= 1'b0;
            fwd_we_reg        <= 1'b0;
        end else begin
            clearing_reg      <= clearing_next;
            sweep_max_reg     <= sweep_max_next;
            sweep_max_bin_reg <= sweep_max_bin_next;
            running_min_reg   <= running_min_next;
            held_level_reg    <= held_level_next;
            held_bin_reg      <= held_bin_next;
            held_valid_reg    <= held_valid_next;
            hold_age_reg      <= hold_age_next;
            auto_trigger_reg  <= auto_trigger_next;
            res_reg           <= res_next;
            fwd_we_reg        <= mem_we;
        end
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    assign res      = res_reg;
    assign held_bin = held_bin_reg;

    a_sweep_close: assert property (@(posedge aclk) disable iff (!aresetn)
        item.valid && item.req == REQ_SAMPLE && item.sweep_end
        |=> sweep_max_reg == '0 && !clearing_reg && held_valid_reg)
        else $error("sweep close left tracking state inconsistent");

    a_blacklist_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        item.valid && item.req == REQ_BLACKLIST |=> !held_valid_reg && held_level_reg == '0)
        else $error("blacklist did not drop the held peak");

endmodule

// ===== hw/rtl/ssph_outq.sv =====
module ssph_outq #(
    parameter int AW = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssph_pkg::res_t              res,
    input  logic [AW-1:0]               held_bin,
    input  logic [ssph_pkg::FREQ_W-1:0] start_freq,
    input  logic [ssph_pkg::STEP_W-1:0] step_size,
    input  logic [1:0]                  pend,
    output logic                        room,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output ssph_pkg::m_beat_t           head
);
    import ssph_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int CNTW   = QPW + 1;
    localparam int PW     = AW + STEP_W;
    localparam int PAD_W  = M_TDATA_W - (2 * BIN_W + 2 * RSSI_W + FREQ_W + 1);

    m_beat_t         q_mem [QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic            push, pop;
    logic [PW-1:0]   prod;
    logic [FREQ_W-1:0] freq;
    logic [CNTW:0]   occ;
    m_beat_t         beat;

    assign prod = PW'(held_bin) * PW'(step_size);
    assign freq = start_freq + FREQ_W'(prod);

    always_comb begin
        beat.tdata = {{PAD_W{1'b0}}, res.over_level, res.floor_level, freq,
                      res.peak_level, BIN_W'(held_bin), res.bin_index};
        beat.tlast = res.sweep_end;
        beat.tuser = res.skipped;
    end

    assign push     = res.valid;
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = q_mem[rd_ptr_reg];

    // everything in flight upstream must still find a slot here
    assign occ  = (CNTW + 1)'(count_reg) + (CNTW + 1)'(pend) - (CNTW + 1)'(pop);
    assign room = occ < (CNTW + 1)'(QDEPTH);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
        if (push) begin
            q_mem[wr_ptr_reg] <= beat;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(QDEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != CNTW'(QDEPTH) || pop)
        else $error("result pushed into a full queue");

endmodule

// ===== hw/rtl/spectrum_sweep_peak_hold_core.sv =====
// channel | dir | handshake            | payload
// s_      | in  | s_tvalid / s_tready  | tdata: rssi; tuser: req_type
// m_      | out | m_tvalid / m_tready  | tdata: result fields; tlast: sweep_end; tuser: skipped
// cfg_    | in  | cfg_valid / cfg_ready| cfg_addr: register index; cfg_data: value
//
// one item per cycle sustained while s_tready is high; the history memory is read in the accept cycle and
// written back the cycle after, with a one-entry bypass for back-to-back hits
// each result passes the item register, the tracking result register and the result queue on its way to m_
// after reset the history memory is zeroed, one address at a time; s_tready stays low
// a four-entry result queue absorbs m_ stalls; s_tready drops once it and the
// pipeline together hold four items and no m_ beat leaves in that cycle
module spectrum_sweep_peak_hold_core #(
    parameter int MAX_BINS = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssph_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] rssi
    input  logic [ssph_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] bin_index, [13:7] peak_bin, [21:14] peak_level, [48:22] peak_freq,
    // [56:49] floor_level, [57] over_level, [63:58] zero
    output logic [ssph_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,   // sweep_end
    output logic [ssph_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] skipped
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssph_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ssph_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssph_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = AW + 1;

    logic [FREQ_W-1:0] start_freq_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic [LOG_W-1:0]  bins_log_reg;
    logic [RSSI_W-1:0] trigger_level_reg;
    logic [HOLD_W-1:0] hold_sweeps_reg;
    logic              cfg_fire, trig_wr;

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic [AW-1:0]     bin_pos_reg, bin_pos_next;
    logic [CW-1:0]     bin_count, pos_inc;
    logic [AW-1:0]     pos_eff;
    logic              a_end, s_fire, q_room;
    req_t              req_in;
    item_t             a_item_reg, a_item_next;
    logic [AW-1:0]     a_pos_reg;

    logic              trk_we, mem_we;
    logic [AW-1:0]     trk_waddr, mem_waddr;
    logic [RSSI_W-1:0] trk_wdata, mem_wdata, hist_rdata;
    res_t              res;
    logic [AW-1:0]     held_bin;
    logic [1:0]        pend;
    m_beat_t           head;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign trig_wr   = cfg_fire && cfg_addr == CFG_TRIGGER_LEVEL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_freq_reg    <= START_FREQ_RST;
            step_size_reg     <= STEP_SIZE_RST;
            bins_log_reg      <= BINS_LOG_RST;
            trigger_level_reg <= TRIGGER_LEVEL_RST;
            hold_sweeps_reg   <= HOLD_SWEEPS_RST;
        end else if (cfg_fire) begin
            case (cfg_addr)
                CFG_START_FREQ:    start_freq_reg    <= cfg_data[FREQ_W-1:0];
                CFG_STEP_SIZE:     step_size_reg     <= cfg_data[STEP_W-1:0];
                CFG_BINS_LOG:      bins_log_reg      <= cfg_data[LOG_W-1:0];
                CFG_TRIGGER_LEVEL: trigger_level_reg <= cfg_data[RSSI_W-1:0];
                CFG_HOLD_SWEEPS:   hold_sweeps_reg   <= cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // history zeroing after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(MAX_BINS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // front stage: bin position and history read
    assign bin_count = CW'(MAX_BINS) >> bins_log_reg;
    assign pos_eff   = (CW'(bin_pos_reg) >= bin_count) ? '0 : bin_pos_reg;
    assign pos_inc   = CW'(pos_eff) + CW'(1);
    assign a_end     = pos_inc >= bin_count;
    assign req_in    = req_t'(s_tuser);
    assign s_tready  = !clr_busy_reg && q_room;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        bin_pos_next = bin_pos_reg;
        if (s_fire) begin
            case (req_in)
                REQ_SAMPLE:  bin_pos_next = a_end ? '0 : pos_inc[AW-1:0];
                REQ_RESTART: bin_pos_next = '0;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        a_item_next.valid     = s_fire;
        a_item_next.req       = req_in;
        a_item_next.rssi      = s_tdata[RSSI_W-1:0];
        a_item_next.sweep_end = req_in == REQ_SAMPLE && a_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_pos_reg      <= '0;
            a_item_reg.valid <= 1'b0;
        end else begin
            bin_pos_reg <= bin_pos_next;
            a_item_reg  <= a_item_next;
        end
        a_pos_reg <= pos_eff;
    end

    assign mem_we    = clr_busy_reg || trk_we;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : trk_waddr;
    assign mem_wdata = clr_busy_reg ? '0 : trk_wdata;

    ssph_ram #(
        .WIDTH (RSSI_W),
        .DEPTH (MAX_BINS)
    ) u_history (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (pos_eff),
        .rdata (hist_rdata)
    );

    ssph_track #(
        .AW (AW)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (a_item_reg),
        .item_pos      (a_pos_reg),
        .hist_rdata    (hist_rdata),
        .trigger_level (trigger_level_reg),
        .hold_sweeps   (hold_sweeps_reg),
        .trig_wr       (trig_wr),
        .mem_we        (trk_we),
        .mem_waddr     (trk_waddr),
        .mem_wdata     (trk_wdata),
        .res           (res),
        .held_bin      (held_bin)
    );

    assign pend = {1'b0, a_item_reg.valid} + {1'b0, res.valid};

    ssph_outq #(
        .AW (AW)
    ) u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res        (res),
        .held_bin   (held_bin),
        .start_freq (start_freq_reg),
        .step_size  (step_size_reg),
        .pend       (pend),
        .room       (q_room),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head       (head)
    );

    assign m_tdata = head.tdata;
    assign m_tlast = head.tlast;
    assign m_tuser = head.tuser;

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !a_item_reg.valid && !res.valid && !trk_we)
        else $error("item in flight during history zeroing");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ssph_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int LONG_STALL      = 60;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 130;
    localparam int SHRINK_ITEMS    = 40;
    localparam int MAX_PRINTED     = 40;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [BIN_W-1:0]  bin_index;
        logic              skipped;
        logic              sweep_end;
        logic [BIN_W-1:0]  peak_bin;
        logic [RSSI_W-1:0] peak_level;
        logic [FREQ_W-1:0] peak_freq;
        logic [RSSI_W-1:0] floor_level;
        logic              over_level;
    } sweep_result_t;

    typedef struct packed {
        req_t              req;
        logic [RSSI_W-1:0] rssi;
        logic              typed;
        sweep_result_t     want;
    } dir_row_t;

    localparam sweep_result_t NO_WANT = '0;

    // run with start 130000000, step 10000, 16 bins, trigger latched, hold 255
    localparam dir_row_t DIRECTED [23] = '{
        '{REQ_RESTART,   8'hAA, 1'b1,
          '{7'd0, 1'b0, 1'b0, 7'd0, 8'd0, 27'd130000000, 8'd255, 1'b1}},
        '{REQ_SAMPLE,    8'hFF, 1'b1,
          '{7'd0, 1'b0, 1'b0, 7'd0, 8'd0, 27'd130000000, 8'd255, 1'b1}},
        '{REQ_SAMPLE,    8'h00, 1'b1,
          '{7'd1, 1'b0, 1'b0, 7'd0, 8'd0, 27'd130000000, 8'd0, 1'b1}},
        '{REQ_SAMPLE,    8'd128, 1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'hFF, 1'b0, NO_WANT},     // ties the max, earlier bin keeps it
        '{REQ_SAMPLE,    8'd1,   1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd254, 1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd100, 1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'h55,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'hAA,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'h0F,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'hF0,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'h33,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'hCC,  1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd200, 1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd7,   1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd9,   1'b0, NO_WANT},    // last bin, closes the sweep
        '{REQ_SAMPLE,    8'd50,  1'b0, NO_WANT},    // blacklisted bin, dropped
        '{REQ_REMEASURE, 8'd90,  1'b0, NO_WANT},
        '{REQ_BLACKLIST, 8'd0,   1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'd3,   1'b0, NO_WANT},
        '{REQ_RESTART,   8'd0,   1'b0, NO_WANT},
        '{REQ_SAMPLE,    8'hFF,  1'b0, NO_WANT}     // refill pass writes over the blacklist
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]      s_tuser   = REQ_SAMPLE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_START_FREQ;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #5 aclk = ~aclk;

    spectrum_sweep_peak_hold_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // predicted block state
    logic [FREQ_W-1:0] cf_start = START_FREQ_RST;
    logic [STEP_W-1:0] cf_step  = STEP_SIZE_RST;
    logic [LOG_W-1:0]  cf_log   = BINS_LOG_RST;
    logic [RSSI_W-1:0] cf_trig  = TRIGGER_LEVEL_RST;
    logic [HOLD_W-1:0] cf_hold  = HOLD_SWEEPS_RST;

    logic [RSSI_W-1:0] bin_hist [128];
    int                cur_bin      = 0;
    logic [RSSI_W-1:0] sw_max       = '0;
    logic [BIN_W-1:0]  sw_max_bin   = '0;
    logic [RSSI_W-1:0] floor_min    = LEVEL_NONE;
    logic [RSSI_W-1:0] pk_level     = '0;
    logic [BIN_W-1:0]  pk_bin       = '0;
    logic              pk_valid     = 1'b0;
    logic [HOLD_W-1:0] pk_age       = '0;
    logic              fill_pass    = 1'b1;
    logic [RSSI_W-1:0] latched_trig = '0;

    sweep_result_t pending_results [$];
    int            mismatches    = 0;
    int            results_seen  = 0;
    bit            sender_choppy = 1'b1;

    function automatic sweep_result_t step_sweep(req_t req, logic [RSSI_W-1:0] rssi);
        sweep_result_t     r;
        int                span;
        logic [63:0]       freq;
        logic [RSSI_W-1:0] trig_eff;
        span = 128 >> cf_log;
        r = '0;
        case (req)
            REQ_SAMPLE: begin
                if (cur_bin >= span)
                    cur_bin = 0;
                r.bin_index = BIN_W'(cur_bin);
                if (!fill_pass && bin_hist[cur_bin] == LEVEL_BLACKLIST) begin
                    r.skipped = 1'b1;
                end else begin
                    bin_hist[cur_bin] = rssi;
                    if (rssi > sw_max) begin
                        sw_max = rssi;
                        sw_max_bin = BIN_W'(cur_bin);
                    end
                    if (rssi < floor_min)
                        floor_min = rssi;
                end
                cur_bin++;
                if (cur_bin >= span) begin
                    r.sweep_end = 1'b1;
                    fill_pass = 1'b0;
                    if (pk_age != AGE_MAX)
                        pk_age++;
                    if (cf_trig == '0 && latched_trig == '0)
                        latched_trig = sw_max;
                    if (!pk_valid || sw_max > pk_level || pk_age >= cf_hold) begin
                        pk_age = '0;
                        pk_level = sw_max;
                        pk_bin = sw_max_bin;
                        pk_valid = 1'b1;
                    end
                    cur_bin = 0;
                    sw_max = '0;
                    sw_max_bin = '0;
                end
            end
            REQ_REMEASURE: begin
                r.bin_index = pk_bin;
                pk_level = rssi;
                bin_hist[pk_bin] = rssi;
            end
            REQ_BLACKLIST: begin
                r.bin_index = pk_bin;
                bin_hist[pk_bin] = LEVEL_BLACKLIST;
                pk_level = '0;
                pk_valid = 1'b0;
            end
            REQ_RESTART: begin
                fill_pass = 1'b1;
                cur_bin = 0;
                sw_max = '0;
                sw_max_bin = '0;
                pk_level = '0;
                pk_valid = 1'b0;
            end
            default: ;
        endcase
        trig_eff = (cf_trig != '0) ? cf_trig : latched_trig;
        freq = 64'(cf_start) + 64'(pk_bin) * 64'(cf_step);
        r.peak_bin = pk_bin;
        r.peak_level = pk_level;
        r.peak_freq = freq[FREQ_W-1:0];
        r.floor_level = floor_min;
        r.over_level = (pk_level >= trig_eff);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_cfg_value(logic [CFG_ADDR_W-1:0] addr);
        logic [CFG_DATA_W-1:0] v;
        int                    r;
        int                    w;
        r = int'($urandom_range(0, 7));
        case (addr)
            CFG_START_FREQ: begin
                w = FREQ_W;
                if (r == 0)      v = 27'd1800000;
                else if (r == 1) v = 27'd130000000;
                else if (r == 2) v = CFG_DATA_W'($urandom);
                else             v = CFG_DATA_W'($urandom_range(1800000, 130000000));
            end
            CFG_STEP_SIZE: begin
                w = STEP_W;
                if (r == 0)      v = 27'd1;
                else if (r == 1) v = 27'd10000;
                else if (r == 2) v = CFG_DATA_W'($urandom_range(0, 16383));
                else             v = CFG_DATA_W'($urandom_range(1, 10000));
            end
            CFG_BINS_LOG: begin
                // mostly short sweeps so that peaks age and get replaced often
                w = LOG_W;
                if (r < 4)       v = 27'd3;
                else if (r < 6)  v = 27'd2;
                else if (r < 7)  v = 27'd1;
                else             v = 27'd0;
            end
            CFG_TRIGGER_LEVEL: begin
                w = RSSI_W;
                if (r < 3)       v = 27'd0;
                else if (r == 3) v = 27'd255;
                else             v = CFG_DATA_W'($urandom_range(1, 254));
            end
            CFG_HOLD_SWEEPS: begin
                w = HOLD_W;
                if (r == 0)      v = 27'd1;
                else if (r == 1) v = 27'd255;
                else if (r == 2) v = 27'd0;
                else             v = CFG_DATA_W'($urandom_range(1, 8));
            end
            default: begin
                w = CFG_DATA_W;
                v = CFG_DATA_W'($urandom);
            end
        endcase
        // junk above the register width now and then
        if (w < CFG_DATA_W && $urandom_range(0, 7) == 0)
            v = v | (CFG_DATA_W'($urandom) << w);
        return v;
    endfunction

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (addr)
            CFG_START_FREQ:    cf_start = data[FREQ_W-1:0];
            CFG_STEP_SIZE:     cf_step = data[STEP_W-1:0];
            CFG_BINS_LOG:      cf_log = data[LOG_W-1:0];
            CFG_TRIGGER_LEVEL: begin
                cf_trig = data[RSSI_W-1:0];
                latched_trig = '0;
            end
            CFG_HOLD_SWEEPS:   cf_hold = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(req_t req, logic [RSSI_W-1:0] rssi, logic typed,
                             sweep_result_t want);
        sweep_result_t predicted;
        int            r;
        int            gap;
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= rssi;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = step_sweep(req, rssi);
        pending_results.push_back(typed ? want : predicted);
        gap = 0;
        if (sender_choppy) begin
            r = int'($urandom_range(0, 9));
            if (r == 9)      gap = int'($urandom_range(5, 30));
            else if (r >= 6) gap = int'($urandom_range(1, 3));
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s wrong on result %0d: got %0d, expected %0d",
                     $time, what, results_seen, got, want);
    endtask

    task automatic check_beat();
        sweep_result_t w;
        if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending", m_tdata, 64'd0);
        end else begin
            w = pending_results.pop_front();
            if (m_tdata[6:0] !== w.bin_index)
                report_mismatch("bin_index", 64'(m_tdata[6:0]), 64'(w.bin_index));
            if (m_tuser[0] !== w.skipped)
                report_mismatch("skipped", 64'(m_tuser[0]), 64'(w.skipped));
            if (m_tlast !== w.sweep_end)
                report_mismatch("sweep_end", 64'(m_tlast), 64'(w.sweep_end));
            if (m_tdata[13:7] !== w.peak_bin)
                report_mismatch("peak_bin", 64'(m_tdata[13:7]), 64'(w.peak_bin));
            if (m_tdata[21:14] !== w.peak_level)
                report_mismatch("peak_level", 64'(m_tdata[21:14]), 64'(w.peak_level));
            if (m_tdata[48:22] !== w.peak_freq)
                report_mismatch("peak_freq", 64'(m_tdata[48:22]), 64'(w.peak_freq));
            if (m_tdata[56:49] !== w.floor_level)
                report_mismatch("floor_level", 64'(m_tdata[56:49]), 64'(w.floor_level));
            if (m_tdata[57] !== w.over_level)
                report_mismatch("over_level", 64'(m_tdata[57]), 64'(w.over_level));
            if (m_tdata[63:58] !== 6'd0)
                report_mismatch("tdata padding", 64'(m_tdata[63:58]), 64'd0);
        end
    endtask

    initial begin : stimulus
        req_t              req;
        logic [RSSI_W-1:0] lvl;
        int                r;
        foreach (bin_hist[i])
            bin_hist[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        cfg_write(CFG_START_FREQ, 27'd130000000);
        cfg_write(CFG_STEP_SIZE, 27'd10000);
        cfg_write(CFG_BINS_LOG, 27'd3);
        cfg_write(CFG_TRIGGER_LEVEL, 27'd0);
        cfg_write(CFG_HOLD_SWEEPS, 27'd255);
        cfg_valid <= 1'b0;
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].req, DIRECTED[i].rssi, DIRECTED[i].typed, DIRECTED[i].want);
        s_tvalid <= 1'b0;

        // long sweep left partly done, then shrunk so the bin position wraps
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_write(CFG_BINS_LOG, 27'd0);
        cfg_write(CFG_TRIGGER_LEVEL, 27'd255);
        cfg_write(CFG_HOLD_SWEEPS, 27'd1);
        cfg_write(CFG_START_FREQ, 27'd1800000);
        cfg_write(CFG_STEP_SIZE, 27'd1);
        cfg_write(CFG_UNUSED_LO, 27'd12345678);
        cfg_write(CFG_UNUSED_HI, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        for (int i = 0; i < SHRINK_ITEMS; i++)
            send_item(REQ_SAMPLE, RSSI_W'($urandom), 1'b0, NO_WANT);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_write(CFG_BINS_LOG, 27'd3);
        cfg_write(CFG_TRIGGER_LEVEL, 27'd0);
        cfg_valid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            while (pending_results.size() != 0) @(posedge aclk);
            if (ph != 0) begin
                for (int a = int'(CFG_START_FREQ); a <= int'(CFG_HOLD_SWEEPS); a++)
                    if ($urandom_range(0, 1) == 1)
                        cfg_write(CFG_ADDR_W'(a), pick_cfg_value(CFG_ADDR_W'(a)));
                if ($urandom_range(0, 4) == 0)
                    cfg_write(CFG_UNUSED_HI, pick_cfg_value(CFG_UNUSED_HI));
                cfg_valid <= 1'b0;
            end
            sender_choppy = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = int'($urandom_range(0, 99));
                if (r < 88)      req = REQ_SAMPLE;
                else if (r < 93) req = REQ_REMEASURE;
                else if (r < 97) req = REQ_BLACKLIST;
                else             req = REQ_RESTART;
                r = int'($urandom_range(0, 99));
                if (r < 5)       lvl = LEVEL_BLACKLIST;
                else if (r < 10) lvl = '0;
                else             lvl = RSSI_W'($urandom);
                send_item(req, lvl, 1'b0, NO_WANT);
            end
            s_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        bit choppy;
        bit long_done;
        stall_left = 0;
        choppy = 1'b1;
        long_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                check_beat();
                results_seen++;
            end
            if ($urandom_range(0, 149) == 0)
                choppy = !choppy;
            if (stall_left == 0 && choppy && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 6) == 0) ? int'($urandom_range(8, 30))
                                                         : int'($urandom_range(1, 3));
            // one long hold-off so the result queue fills and s_tready drops
            if (results_seen >= 400 && !long_done) begin
                stall_left = LONG_STALL;
                long_done = 1'b1;
            end
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
